[design/psc_pkg.sv]
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies.
package psc_pkg;

    localparam logic [1:0] CFG_TEMP_CAL    = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;
    localparam logic [1:0] CFG_PRESS_NINE  = 2'd3;

    localparam int unsigned DIV_STAGES = 32;

    localparam logic [31:0] K_P_OFFSET  = 32'd64000;
    localparam logic [31:0] K_P_BASE    = 32'd1048576;
    localparam logic [31:0] K_P_SCALE   = 32'd3125;
    localparam logic [31:0] K_V1_BIAS   = 32'd32768;
    localparam logic [31:0] K_T_ROUND   = 32'd128;

    // carried alongside the divider
    typedef struct packed {
        logic        op;
        logic        zero;
        logic        post;   // quotient gets doubled afterwards
        logic [31:0] temp;
    } t_side;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

endpackage

[design/psc_div.sv]
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on psc_pkg.
module psc_div import psc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  t_side       i_side,
    output logic        o_valid,
    output logic [31:0] o_quot,
    output t_side       o_side
);

    logic        r_val  [DIV_STAGES];
    logic [31:0] r_rem  [DIV_STAGES];
    logic [31:0] r_dq   [DIV_STAGES];
    logic [31:0] r_div  [DIV_STAGES];
    t_side       r_side [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic        w_val;
        logic [31:0] w_rem;
        logic [31:0] w_dq;
        logic [31:0] w_div;
        t_side       w_side;
        logic [32:0] w_sh;
        logic [32:0] w_diff;

        if (i == 0) begin : g_first
            assign w_val  = i_valid;
            assign w_rem  = '0;
            assign w_dq   = i_dividend;
            assign w_div  = i_divisor;
            assign w_side = i_side;
        end else begin : g_next
            assign w_val  = r_val[i-1];
            assign w_rem  = r_rem[i-1];
            assign w_dq   = r_dq[i-1];
            assign w_div  = r_div[i-1];
            assign w_side = r_side[i-1];
        end

        assign w_sh   = {w_rem, w_dq[31]};
        assign w_diff = w_sh - {1'b0, w_div};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[i] <= 1'b0;
            end else if (i_en) begin
                r_val[i] <= w_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= w_diff[32] ? w_sh[31:0] : w_diff[31:0];
                r_dq[i]   <= {w_dq[30:0], ~w_diff[32]};
                r_div[i]  <= w_div;
                r_side[i] <= w_side;
            end
        end
    end

    assign o_valid = r_val[DIV_STAGES-1];
    assign o_quot  = r_dq[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

    // a restoring step leaves the partial remainder below a nonzero divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val[DIV_STAGES-1] |-> (r_rem[DIV_STAGES-1] < r_div[DIV_STAGES-1]))
        else $error("divider remainder not below divisor");

endmodule

[design/pressure_temp_compensation.sv]
// Top level of the barometric compensation block (32-bit integer formula).
// Depends on psc_pkg and psc_div.
//
// Usage: software loads the calibration words through the write port
// (index 0 T1..T3, 1 P1..P4, 2 P5..P8, 3 P9) while the block is idle.
// A request on the slave stream carries raw pressure and raw temperature in
// tdata and the op in tuser (0 temperature, 1 pressure). Each request yields
// exactly one result on the master stream: value in tdata, divisor-zero flag
// in tuser.
// From acceptance to the result register the pipeline has ten stages
// of fine temperature and pressure arithmetic, 32 stages of the bit-serial
// divider (one quotient bit per stage), three stages of final correction.
// Throughput is one request per cycle when not stalled; the divider pipeline sets the depth.
// The whole pipeline advances together; when the receiver stalls with a
// result held, every stage holds and the slave tready drops, so nothing is
// lost or repeated. Reset clears all valid bits and calibration words.
module pressure_temp_compensation import psc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [19:0] raw_pressure, [39:20] raw_temperature
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] value
    output logic        o_m_axis_tuser    // [0] divisor_zero
);

    logic [47:0] r_tcal;
    logic [63:0] r_pcal_lo;
    logic [63:0] r_pcal_hi;
    logic [15:0] r_p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal    <= '0;
            r_pcal_lo <= '0;
            r_pcal_hi <= '0;
            r_p9      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP_CAL:   r_tcal    <= i_cfg_wdata[47:0];
                CFG_PRESS_LOW:  r_pcal_lo <= i_cfg_wdata;
                CFG_PRESS_HIGH: r_pcal_hi <= i_cfg_wdata;
                CFG_PRESS_NINE: r_p9      <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    logic [31:0] w_t1, w_t2, w_t3, w_p1, w_p2, w_p3, w_p4;
    logic [31:0] w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_t1 = {16'd0, r_tcal[15:0]};
    assign w_t2 = sext16(r_tcal[31:16]);
    assign w_t3 = sext16(r_tcal[47:32]);
    assign w_p1 = {16'd0, r_pcal_lo[15:0]};
    assign w_p2 = sext16(r_pcal_lo[31:16]);
    assign w_p3 = sext16(r_pcal_lo[47:32]);
    assign w_p4 = sext16(r_pcal_lo[63:48]);
    assign w_p5 = sext16(r_pcal_hi[15:0]);
    assign w_p6 = sext16(r_pcal_hi[31:16]);
    assign w_p7 = sext16(r_pcal_hi[47:32]);
    assign w_p8 = sext16(r_pcal_hi[63:48]);
    assign w_p9 = sext16(r_p9);

    logic w_adv;
    assign w_adv           = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    logic [19:0] w_adc_p, w_adc_t;
    assign w_adc_p = i_s_axis_tdata[19:0];
    assign w_adc_t = i_s_axis_tdata[39:20];

    // valid and op per stage, A..J
    logic        r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi, r_vj;
    logic        r_opa, r_opb, r_opc, r_opd, r_ope, r_opf, r_opg, r_oph, r_opi, r_opj;
    logic [19:0] r_pa, r_pb, r_pc, r_pd, r_pe, r_pf, r_pg, r_ph;
    logic [31:0] r_tmf, r_tmg, r_tmh, r_tmi, r_tmj;
    logic [31:0] r_x1, r_d, r_a, r_dd, r_as, r_b, r_tf;
    logic [31:0] r_temp, r_v1, r_q, r_sq, r_m5, r_m2, r_m6, r_m3, r_m5g, r_m2g;
    logic [31:0] r_v2, r_v1b, r_m1, r_pn, r_v1c, r_p;

    logic [31:0] n_temp, n_v1, n_tf5, n_v2sum;
    assign n_tf5   = (r_tf << 2) + r_tf + K_T_ROUND;
    assign n_temp  = $unsigned($signed(n_tf5) >>> 8);
    assign n_v1    = $unsigned($signed(r_tf) >>> 1) - K_P_OFFSET;
    assign n_v2sum = r_m6 + (r_m5g << 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi, r_vj} <= '0;
        end else if (w_adv) begin
            r_va <= i_s_axis_tvalid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
            r_vf <= r_ve;
            r_vg <= r_vf;
            r_vh <= r_vg;
            r_vi <= r_vh;
            r_vj <= r_vi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // A: offsets of raw temperature
            r_opa <= i_s_axis_tuser;
            r_pa  <= w_adc_p;
            r_x1  <= {15'd0, w_adc_t[19:3]} - (w_t1 << 1);
            r_d   <= {16'd0, w_adc_t[19:4]} - w_t1;
            // B
            r_opb <= r_opa;
            r_pb  <= r_pa;
            r_a   <= r_x1 * w_t2;
            r_dd  <= r_d * r_d;
            // C
            r_opc <= r_opb;
            r_pc  <= r_pb;
            r_as  <= $unsigned($signed(r_a) >>> 11);
            r_b   <= $unsigned($signed(r_dd) >>> 12) * w_t3;
            // D: fine temperature
            r_opd <= r_opc;
            r_pd  <= r_pc;
            r_tf  <= r_as + $unsigned($signed(r_b) >>> 14);
            // E
            r_ope  <= r_opd;
            r_pe   <= r_pd;
            r_temp <= n_temp;
            r_v1   <= n_v1;
            r_q    <= $unsigned($signed(n_v1) >>> 2);
            // F
            r_opf <= r_ope;
            r_pf  <= r_pe;
            r_tmf <= r_temp;
            r_sq  <= r_q * r_q;
            r_m5  <= r_v1 * w_p5;
            r_m2  <= w_p2 * r_v1;
            // G
            r_opg <= r_opf;
            r_pg  <= r_pf;
            r_tmg <= r_tmf;
            r_m6  <= $unsigned($signed(r_sq) >>> 11) * w_p6;
            r_m3  <= w_p3 * $unsigned($signed(r_sq) >>> 13);
            r_m5g <= r_m5;
            r_m2g <= r_m2;
            // H
            r_oph <= r_opg;
            r_ph  <= r_pg;
            r_tmh <= r_tmg;
            r_v2  <= $unsigned($signed(n_v2sum) >>> 2) + (w_p4 << 16);
            r_v1b <= $unsigned(($signed($unsigned($signed(r_m3) >>> 3)
                     + $unsigned($signed(r_m2g) >>> 1))) >>> 18);
            // I
            r_opi <= r_oph;
            r_tmi <= r_tmh;
            r_m1  <= (K_V1_BIAS + r_v1b) * w_p1;
            r_pn  <= (K_P_BASE - {12'd0, r_ph}) - $unsigned($signed(r_v2) >>> 12);
            // J
            r_opj <= r_opi;
            r_tmj <= r_tmi;
            r_v1c <= $unsigned($signed(r_m1) >>> 15);
            r_p   <= r_pn * K_P_SCALE;
        end
    end

    // divider front: branch on the top bit of the scaled pressure
    t_side       w_dside, w_qside;
    logic        w_dzero, w_qvalid;
    logic [31:0] w_quot;
    assign w_dzero       = (r_v1c == '0);
    assign w_dside.op    = r_opj;
    assign w_dside.zero  = w_dzero;
    assign w_dside.post  = r_p[31];
    assign w_dside.temp  = r_tmj;

    psc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_vj),
        .i_dividend (r_p[31] ? r_p : (r_p << 1)),
        .i_divisor  (w_dzero ? 32'd1 : r_v1c),
        .i_side     (w_dside),
        .o_valid    (w_qvalid),
        .o_quot     (w_quot),
        .o_side     (w_qside)
    );

    logic [31:0] n_px;
    assign n_px = w_qside.post ? (w_quot << 1) : w_quot;

    logic        r_vx, r_vy, r_vz;
    t_side       r_sx, r_sy;
    logic [31:0] r_xp, r_s8, r_m8, r_yp, r_m9, r_m8s, r_value;
    logic        r_zflag;
    logic [31:0] n_corr, n_value;

    assign n_corr  = $unsigned($signed(r_m9) >>> 12) + r_m8s + w_p7;
    assign n_value = !r_sy.op ? r_sy.temp :
                     r_sy.zero ? 32'd0 : r_yp + $unsigned($signed(n_corr) >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx <= 1'b0;
            r_vy <= 1'b0;
            r_vz <= 1'b0;
        end else if (w_adv) begin
            r_vx <= w_qvalid;
            r_vy <= r_vx;
            r_vz <= r_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sx    <= w_qside;
            r_xp    <= n_px;
            r_s8    <= {3'd0, n_px[31:3]} * {3'd0, n_px[31:3]};
            r_m8    <= {2'd0, n_px[31:2]} * w_p8;
            r_sy    <= r_sx;
            r_yp    <= r_xp;
            r_m9    <= w_p9 * {13'd0, r_s8[31:13]};
            r_m8s   <= $unsigned($signed(r_m8) >>> 13);
            r_value <= n_value;
            r_zflag <= r_sy.op & r_sy.zero;
        end
    end

    assign o_m_axis_tvalid = r_vz;
    assign o_m_axis_tdata  = r_value;
    assign o_m_axis_tuser  = r_zflag;

    a_zero_forces_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("divisor-zero result carries nonzero value");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    a_flag_only_pressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vy && w_adv && !r_sy.op) |=> !o_m_axis_tuser)
        else $error("divisor-zero flag on a temperature result");

endmodule
